FILE: src/cfe_pkg.sv
// Shared types and constants for the COBS frame encoder.
// Defines the result beat, the per-item write packet and register indexes.
// No dependencies.
package cfe_pkg;

    localparam int          QDEPTH       = 4;
    localparam int          MAX_WRITES   = 4;
    localparam int          CNT_W        = 3;
    localparam int          PADDR_W      = 3;
    localparam logic [0:0]  IDX_CAPACITY = 1'b0;
    localparam logic [15:0] CAP_RESET    = 16'd1024;
    localparam logic [7:0]  CODE_MAX     = 8'hFF;
    localparam logic [7:0]  DELIMITER    = 8'h00;

    typedef struct packed {
        logic [15:0] write_addr;
        logic [7:0]  write_byte;
        logic        frame_done;
        logic        overflow;
    } t_res;

    // All buffer writes caused by one input item, in issue order.
    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        t_res [MAX_WRITES-1:0]       res;
    } t_pkt;

endpackage

FILE: src/cfe_front.sv
// Front end of the COBS frame encoder: holds the frame state and turns each
// accepted item into a packet of up to four buffer writes.
// Depends on cfe_pkg.
module cfe_front #(
    parameter int ADDR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_has_byte,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_payload,
    input  logic [ADDR_WIDTH-1:0] i_cap_eff,
    output cfe_pkg::t_pkt         o_pkt
);
    import cfe_pkg::*;

    localparam int PW = ADDR_WIDTH + 1;

    logic [ADDR_WIDTH-1:0] r_code_pos, n_code_pos;
    logic [ADDR_WIDTH-1:0] r_next_pos, n_next_pos;
    logic [7:0]            r_block_code, n_block_code;
    logic                  r_discarding, n_discarding;

    function automatic t_pkt f_emit(t_pkt p, logic [PW-1:0] addr, logic [7:0] data,
                                    logic done, logic ovf);
        t_pkt q;
        q = p;
        q.res[p.cnt[1:0]].write_addr = 16'(addr);
        q.res[p.cnt[1:0]].write_byte = data;
        q.res[p.cnt[1:0]].frame_done = done;
        q.res[p.cnt[1:0]].overflow   = ovf;
        q.cnt = p.cnt + CNT_W'(1);
        return q;
    endfunction

    always_comb begin
        logic [PW-1:0] v_cp;
        logic [PW-1:0] v_np;
        logic [PW-1:0] v_cap;
        logic [7:0]    v_bc;
        logic          v_ovf;
        logic          v_restart;
        t_pkt          v_pkt;

        v_pkt        = '0;
        v_cp         = {1'b0, r_code_pos};
        v_np         = {1'b0, r_next_pos};
        v_cap        = {1'b0, i_cap_eff};
        v_bc         = r_block_code;
        v_ovf        = 1'b0;
        v_restart    = 1'b0;
        n_code_pos   = r_code_pos;
        n_next_pos   = r_next_pos;
        n_block_code = r_block_code;
        n_discarding = r_discarding;

        if (r_discarding) begin
            if (i_end_of_payload) begin
                n_discarding = 1'b0;
                v_restart    = 1'b1;
            end
        end else if (i_has_byte || i_end_of_payload) begin
            if (v_cap < PW'(2)) begin
                v_ovf = 1'b1;
            end else if (i_has_byte) begin
                if (i_data_byte == 8'h00) begin
                    v_pkt = f_emit(v_pkt, v_cp, v_bc, 1'b0, 1'b0);
                    v_bc  = 8'd1;
                    v_cp  = v_np;
                    v_np  = v_np + PW'(1);
                    v_ovf = (v_np >= v_cap);
                end else if (v_np >= v_cap) begin
                    v_ovf = 1'b1;
                end else begin
                    v_pkt = f_emit(v_pkt, v_np, i_data_byte, 1'b0, 1'b0);
                    v_np  = v_np + PW'(1);
                    v_bc  = v_bc + 8'd1;
                    // A full block closes at once and a fresh one opens behind it.
                    if (v_bc == CODE_MAX) begin
                        v_pkt = f_emit(v_pkt, v_cp, v_bc, 1'b0, 1'b0);
                        v_bc  = 8'd1;
                        v_cp  = v_np;
                        v_np  = v_np + PW'(1);
                        v_ovf = (v_np >= v_cap);
                    end
                end
            end

            if (!v_ovf && i_end_of_payload) begin
                v_pkt = f_emit(v_pkt, v_cp, v_bc, 1'b0, 1'b0);
                if (v_np >= v_cap) begin
                    v_ovf = 1'b1;
                end else begin
                    v_pkt     = f_emit(v_pkt, v_np, DELIMITER, 1'b1, 1'b0);
                    v_restart = 1'b1;
                end
            end

            if (v_ovf) begin
                v_pkt        = f_emit(v_pkt, '0, 8'h00, 1'b1, 1'b1);
                v_restart    = 1'b1;
                n_discarding = !i_end_of_payload;
            end else if (!v_restart) begin
                n_code_pos   = v_cp[ADDR_WIDTH-1:0];
                n_next_pos   = v_np[ADDR_WIDTH-1:0];
                n_block_code = v_bc;
            end
        end

        if (v_restart) begin
            n_code_pos   = '0;
            n_next_pos   = ADDR_WIDTH'(1);
            n_block_code = 8'd1;
        end

        o_pkt = v_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_pos   <= '0;
            r_next_pos   <= ADDR_WIDTH'(1);
            r_block_code <= 8'd1;
            r_discarding <= 1'b0;
        end else if (i_accept) begin
            r_code_pos   <= n_code_pos;
            r_next_pos   <= n_next_pos;
            r_block_code <= n_block_code;
            r_discarding <= n_discarding;
        end
    end

endmodule

FILE: src/cfe_queue.sv
// Short packet queue between the front end and the write issuer.
// Holds whole write packets so each side can stall on its own.
// Depends on cfe_pkg.
module cfe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfe_pkg::t_pkt i_pkt,
    input  logic          i_pop,
    output cfe_pkg::t_pkt o_head,
    output logic          o_empty,
    output logic          o_full
);
    import cfe_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CW    = $clog2(QDEPTH + 1);

    t_pkt             r_mem [QDEPTH];
    t_pkt             r_head;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PTR_W-1:0] w_rd_next;

    assign w_rd_next = r_rd_ptr + PTR_W'(1);
    assign o_head    = r_head;
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(QDEPTH));

    // The head register always holds the oldest packet. It is refilled from
    // the next entry on a pop, or straight from the input when the incoming
    // packet becomes the oldest one.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
        if (i_pop && (r_count > CW'(1))) begin
            r_head <= r_mem[w_rd_next];
        end else if (i_push && ((r_count == '0) || i_pop)) begin
            r_head <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: src/cfe_back.sv
// Write issuer: moves the head packet into the output register one write per
// cycle unless stalled; frees it after its last write. Depends on cfe_pkg.
module cfe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfe_pkg::t_pkt i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output cfe_pkg::t_res o_res
);
    import cfe_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_res       r_res;
    logic       w_load;
    logic       w_last;

    // The output register takes a new beat when it is empty or being taken.
    assign w_load  = !i_empty && (!r_valid || !i_stall);
    assign w_last  = (({1'b0, r_idx} + CNT_W'(1)) == i_head.cnt);
    assign o_pop   = w_load && w_last;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_head.res[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/cobs_frame_encoder_core.sv
// COBS frame encoder: payload bytes in, frame buffer writes out. Depends on cfe_pkg.
// A write passes through the queue head and output registers before it is presented.
// Throughput: one item per cycle while each item makes one write; writes leave one
// per cycle while i_stall is low, and a four-packet queue absorbs items that make up
// to four, stalling input only when full. Synchronous active-low reset restores the
// frame state, sets buffer_capacity to 1024 and empties the queue and output.
module cobs_frame_encoder_core #(
    parameter int ADDR_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_has_byte,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_payload,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [15:0]                 o_write_addr,
    output logic [7:0]                  o_write_byte,
    output logic                        o_frame_done,
    output logic                        o_overflow,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfe_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cfe_pkg::*;

    localparam logic [31:0] CapLimit = (32'd1 << ADDR_WIDTH) - 32'd1;

    logic [15:0]           r_buffer_capacity;
    logic [31:0]           w_cap32;
    logic [ADDR_WIDTH-1:0] w_cap_eff;
    logic                  w_accept;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_empty;
    logic                  w_full;
    t_pkt                  w_pkt;
    t_pkt                  w_head;
    t_res                  w_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == IDX_CAPACITY) ? {16'h0000, r_buffer_capacity} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == IDX_CAPACITY)) begin
            r_buffer_capacity <= pwdata[15:0];
        end
    end

    // The capacity in use cannot exceed the largest address.
    assign w_cap32   = (32'(r_buffer_capacity) < CapLimit) ? 32'(r_buffer_capacity) : CapLimit;
    assign w_cap_eff = w_cap32[ADDR_WIDTH-1:0];

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;
    assign w_push   = w_accept && (w_pkt.cnt != '0);

    cfe_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_has_byte       (i_has_byte),
        .i_data_byte      (i_data_byte),
        .i_end_of_payload (i_end_of_payload),
        .i_cap_eff        (w_cap_eff),
        .o_pkt            (w_pkt)
    );

    cfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_pkt),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    cfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_res)
    );

    assign o_write_addr = w_res.write_addr;
    assign o_write_byte = w_res.write_byte;
    assign o_frame_done = w_res.frame_done;
    assign o_overflow   = w_res.overflow;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for cobs_frame_encoder_core: drives payload beats,
// predicts every frame buffer write and compares it with the block's output.
// Depends on cfe_pkg and the encoder RTL only.
module tb;
    import cfe_pkg::*;

    localparam int                 WATCHDOG_LIMIT = 4000;
    localparam int                 HOLD_CYCLES    = 80;
    localparam logic [PADDR_W-1:0] CAP_ADDR       = PADDR_W'(4 * IDX_CAPACITY);

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        i_has_byte       = 1'b0;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_end_of_payload = 1'b0;
    logic        i_stall          = 1'b0;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0] pwdata           = '0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_write_addr;
    logic [7:0]  o_write_byte;
    logic        o_frame_done;
    logic        o_overflow;
    logic [31:0] prdata;
    logic        pready;

    cobs_frame_encoder_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_has_byte       (i_has_byte),
        .i_data_byte      (i_data_byte),
        .i_end_of_payload (i_end_of_payload),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_write_addr     (o_write_addr),
        .o_write_byte     (o_write_byte),
        .o_frame_done     (o_frame_done),
        .o_overflow       (o_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 i_clk = ~i_clk;

    // Encoder state as the testbench tracks it.
    logic [15:0] cap_model = CAP_RESET;
    int unsigned code_pos  = 0;
    int unsigned next_pos  = 1;
    int unsigned blk_code  = 1;
    bit          dropping  = 1'b0;

    t_res        pending_writes[$];

    int fail_count    = 0;
    int items_encoded = 0;
    int writes_seen   = 0;
    int aborts_seen   = 0;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    task automatic push_write(input int unsigned addr, input int unsigned data,
                              input bit done, input bit ovf);
        t_res w;
        w.write_addr = addr[15:0];
        w.write_byte = data[7:0];
        w.frame_done = done;
        w.overflow   = ovf;
        pending_writes.push_back(w);
    endtask

    task automatic restart_frame();
        code_pos = 0;
        next_pos = 1;
        blk_code = 1;
    endtask

    // Back-patch the open block's code byte and open a new block.
    task automatic close_block();
        push_write(code_pos, blk_code, 1'b0, 1'b0);
        blk_code = 1;
        code_pos = next_pos;
        next_pos = next_pos + 1;
    endtask

    task automatic encode_item(input logic has, input logic [7:0] data, input logic eop);
        bit ovf;
        ovf = 1'b0;
        if (dropping) begin
            if (eop) begin
                dropping = 1'b0;
                restart_frame();
            end
            return;
        end
        if (!has && !eop)
            return;
        items_encoded++;
        if (cap_model < 2) begin
            ovf = 1'b1;
        end else if (has) begin
            if (data == 8'h00) begin
                close_block();
                if (next_pos >= cap_model) ovf = 1'b1;
            end else if (next_pos >= cap_model) begin
                ovf = 1'b1;
            end else begin
                push_write(next_pos, data, 1'b0, 1'b0);
                next_pos = next_pos + 1;
                blk_code = blk_code + 1;
                if (blk_code == CODE_MAX) begin
                    close_block();
                    if (next_pos >= cap_model) ovf = 1'b1;
                end
            end
        end
        if (!ovf && eop) begin
            push_write(code_pos, blk_code, 1'b0, 1'b0);
            if (next_pos >= cap_model) begin
                ovf = 1'b1;
            end else begin
                push_write(next_pos, DELIMITER, 1'b1, 1'b0);
                restart_frame();
                return;
            end
        end
        if (ovf) begin
            push_write(0, 0, 1'b1, 1'b1);
            restart_frame();
            dropping = !eop;
        end
    endtask

    // Offer one beat, with a random gap first, and wait until it is taken.
    task automatic send_item(input logic has, input logic [7:0] data, input logic eop);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_has_byte       <= has;
        i_data_byte      <= data;
        i_end_of_payload <= eop;
        do @(posedge i_clk); while (o_stall);
        encode_item(has, data, eop);
    endtask

    task automatic wait_writes_done();
        i_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_capacity(input logic [15:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("capacity read back %0d, expected %0d", prdata[15:0], want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(input logic [31:0] wdata);
        wait_writes_done();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= wdata;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cap_model = wdata[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        check_capacity(wdata[15:0]);
    endtask

    // A frame of random length, mostly nonzero bytes, sometimes ended by an
    // empty end beat, with the odd idle beat mixed in.
    task automatic send_random_frame(input int max_len);
        int len;
        bit sep_end;
        logic [7:0] data;
        len     = $urandom_range(0, max_len);
        sep_end = ($urandom_range(0, 99) < 20);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 10)
                send_item(1'b0, 8'($urandom), 1'b0);
            data = ($urandom_range(0, 99) < 25) ? 8'h00 : 8'($urandom_range(1, 255));
            send_item(1'b1, data, (i == len - 1) && !sep_end);
        end
        if (len == 0 || sep_end)
            send_item(1'b0, 8'($urandom), 1'b1);
    endtask

    task automatic test_basic_frames();
        check_capacity(CAP_RESET);
        send_item(1'b0, 8'hA5, 1'b1);
        send_item(1'b0, 8'h5A, 1'b0);
        send_item(1'b1, 8'h00, 1'b1);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, 8'h01, 1'b0);
        send_item(1'b1, 8'h80, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'h7F, 1'b1);
        send_item(1'b1, 8'h55, 1'b0);
        send_item(1'b1, 8'hAA, 1'b0);
        send_item(1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_capacity_edges();
        // Too small for any frame: the first beat aborts and the rest is dropped.
        set_capacity({16'hBEEF, 16'd1});
        send_item(1'b1, 8'h12, 1'b0);
        send_item(1'b1, 8'h34, 1'b0);
        send_item(1'b0, 8'h00, 1'b0);
        send_item(1'b1, 8'h56, 1'b1);
        send_item(1'b1, 8'h00, 1'b1);
        set_capacity(32'd0);
        send_item(1'b0, 8'h00, 1'b1);
        // Room for data but not for the delimiter.
        set_capacity(32'd2);
        send_item(1'b1, 8'h11, 1'b1);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b0, 8'hFF, 1'b1);
        set_capacity(32'd3);
        send_item(1'b1, 8'h05, 1'b0);
        send_item(1'b1, 8'h06, 1'b1);
    endtask

    // Just long enough for a full block to close on its own; the last byte also
    // ends the payload, so that one beat makes four writes.
    task automatic test_long_block();
        set_capacity(32'h0000_FFFF);
        for (int i = 0; i < 254; i++)
            send_item(1'b1, 8'($urandom_range(1, 255)), i == 253);
    endtask

    task automatic test_idle_mixes();
        int gaps[4]  = '{0, 50, 0, 34};
        int stalls[4] = '{0, 0, 50, 34};
        int start;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_capacity(32'($urandom_range(2, 12)));
                1: set_capacity({16'($urandom), 16'hFFFF});
                2: set_capacity(32'($urandom_range(2, 40)));
                default: set_capacity(32'($urandom_range(3, 20)));
            endcase
            send_gap_pct = gaps[p];
            stall_pct    = stalls[p];
            start        = items_encoded;
            while (items_encoded - start < 10)
                send_random_frame(10);
        end
        send_gap_pct = 0;
        stall_pct    = 0;
    endtask

    task automatic test_backpressure();
        set_capacity(32'd1024);
        hold_reqs++;
        for (int i = 0; i < 20; i++)
            send_item(1'b1, (i % 3 == 0) ? 8'h00 : 8'($urandom_range(1, 255)), i % 5 == 4);
        send_item(1'b0, 8'h00, 1'b1);
        wait_writes_done();
        stall_pct = 20;
        for (int i = 0; i < 4; i++)
            send_random_frame(6);
        stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            writes_seen++;
            if (o_overflow === 1'b1) aborts_seen++;
            if (pending_writes.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected write: addr %0d byte %h done %b ovf %b",
                             o_write_addr, o_write_byte, o_frame_done, o_overflow);
            end else begin
                want = pending_writes.pop_front();
                if (o_write_addr !== want.write_addr || o_write_byte !== want.write_byte ||
                    o_frame_done !== want.frame_done || o_overflow !== want.overflow) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: want %0d %h %b %b, got %0d %h %b %b",
                                 want.write_addr, want.write_byte, want.frame_done,
                                 want.overflow, o_write_addr, o_write_byte,
                                 o_frame_done, o_overflow);
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out with %0d writes outstanding", pending_writes.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_frames();
        test_capacity_edges();
        test_long_block();
        test_idle_mixes();
        test_backpressure();
        wait_writes_done();
        repeat (8) @(posedge i_clk);
        if (pending_writes.size() != 0)
            fail_count++;
        $display("Encoded %0d payload beats into %0d buffer writes, %0d of them aborts,",
                 items_encoded, writes_seen, aborts_seen);
        $display("with capacities from 0 to 65535, four idling mixes and a long output hold.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
